>>> hw/rtl/cffsa_pkg.sv
package cffsa_pkg;

    localparam int SEATS      = 1024;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = SEATS / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);

    localparam int SLOT_W   = 10;
    localparam int DIST_W   = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    localparam logic [CFG_W-1:0] SEATS_RESET = 11'd1024;
    localparam logic [CFG_W-1:0] RING_MAX    = CFG_W'(SEATS);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ASSIGNED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_sts_t;

endpackage

>>> hw/rtl/cffsa_ctrl.sv
module cffsa_ctrl
    import cffsa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign s_tready     = (state_reg == S_IDLE);
    assign m_tvalid     = out_valid_reg;
    assign cmd.load     = s_tvalid && s_tready;
    assign cmd.step     = (state_reg == S_SEARCH);
    assign cmd.load_out = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sts.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/cffsa_dp.sv
module cffsa_dp
    import cffsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                cfg_valid,
    input  logic [CFG_W-1:0]    cfg_data,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0] m_tuser
);

    logic [CFG_W-1:0]      seats_reg;
    logic [WORD_BITS-1:0]  map_reg [MAP_WORDS];
    logic                  clear_reg;
    logic [SLOT_W-1:0]     wanted_reg;
    logic [WORD_IDX_W-1:0] ptr_reg;
    logic                  phase_reg;
    logic [SLOT_W-1:0]     rslot_reg;
    logic [STATUS_W-1:0]   rstatus_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic [CFG_W-1:0]      ring;
    logic                  out_of_range;
    logic [SLOT_W-1:0]     last_slot;
    logic [WORD_IDX_W-1:0] last_word;
    logic [BIT_IDX_W-1:0]  last_bit;
    logic [WORD_IDX_W-1:0] want_word;
    logic [BIT_IDX_W-1:0]  want_bit;
    logic [WORD_BITS-1:0]  free_bits;
    logic                  hit;
    logic [BIT_IDX_W-1:0]  hit_bit;
    logic                  is_last;
    logic [DIST_W-1:0]     slot_ext;
    logic [DIST_W-1:0]     want_ext;
    logic [DIST_W-1:0]     walk_len;

    assign ring         = (seats_reg > RING_MAX) ? RING_MAX : seats_reg;
    assign out_of_range = ({1'b0, wanted_reg} >= ring);
    assign last_slot    = SLOT_W'(ring - CFG_W'(1));
    assign last_word    = last_slot[SLOT_W-1:BIT_IDX_W];
    assign last_bit     = last_slot[BIT_IDX_W-1:0];
    assign want_word    = wanted_reg[SLOT_W-1:BIT_IDX_W];
    assign want_bit     = wanted_reg[BIT_IDX_W-1:0];

    // A bit is searchable when it lies inside the ring and inside the
    // current pass: at or after the wanted slot first, before it after the wrap.
    always_comb
    begin
        logic                 ok;
        logic [BIT_IDX_W-1:0] bb;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            bb = BIT_IDX_W'(b);
            ok = 1'b1;
            if ((ptr_reg == last_word) && (bb > last_bit))
            begin
                ok = 1'b0;
            end
            if (ptr_reg == want_word)
            begin
                if (!phase_reg && (bb < want_bit))
                begin
                    ok = 1'b0;
                end
                if (phase_reg && (bb >= want_bit))
                begin
                    ok = 1'b0;
                end
            end
            free_bits[b] = ok && !map_reg[ptr_reg][b];
        end
    end

    always_comb
    begin
        hit_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                hit_bit = BIT_IDX_W'(b);
            end
        end
    end

    assign hit      = |free_bits;
    assign is_last  = phase_reg && (ptr_reg == want_word);
    assign sts.done = clear_reg || out_of_range || hit || is_last;

    assign slot_ext = {1'b0, rslot_reg};
    assign want_ext = {1'b0, wanted_reg};
    assign walk_len = (slot_ext >= want_ext) ? (slot_ext - want_ext + DIST_W'(1))
                                             : (slot_ext + ring - want_ext + DIST_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seats_reg <= SEATS_RESET;
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                map_reg[w] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                seats_reg <= cfg_data;
            end
            if (cmd.step)
            begin
                if (clear_reg == CMD_CLEAR)
                begin
                    for (int w = 0; w < MAP_WORDS; w++)
                    begin
                        map_reg[w] <= '0;
                    end
                end
                else if (!out_of_range && hit)
                begin
                    map_reg[ptr_reg][hit_bit] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clear_reg  <= s_tuser;
            wanted_reg <= s_tdata[SLOT_W-1:0];
            ptr_reg    <= s_tdata[SLOT_W-1:BIT_IDX_W];
            phase_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (clear_reg == CMD_CLEAR)
            begin
                rstatus_reg <= ST_CLEARED;
            end
            else if (out_of_range)
            begin
                rstatus_reg <= ST_RANGE;
            end
            else if (hit)
            begin
                rstatus_reg <= ST_ASSIGNED;
                rslot_reg   <= {ptr_reg, hit_bit};
            end
            else if (is_last)
            begin
                rstatus_reg <= ST_FULL;
            end
            else if (ptr_reg == last_word)
            begin
                ptr_reg   <= '0;
                phase_reg <= 1'b1;
            end
            else
            begin
                ptr_reg <= ptr_reg + WORD_IDX_W'(1);
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= rstatus_reg;
            if (rstatus_reg == ST_ASSIGNED)
            begin
                out_slot_reg <= rslot_reg;
                out_dist_reg <= walk_len;
            end
            else
            begin
                out_slot_reg <= '0;
                out_dist_reg <= '0;
            end
        end
    end

    assign m_tdata = {(M_DATA_W - SLOT_W - DIST_W)'(0), out_dist_reg, out_slot_reg};
    assign m_tuser = out_status_reg;

endmodule

>>> hw/rtl/circular_first_free_slot_allocator.sv
// Circular first-free slot allocator for a ring of up to 1024 slots.
// A beat on the s_ channel carries one request: tuser 0 allocates the first
// free slot at or after tdata's wanted slot, wrapping at the ring end, and
// tuser 1 frees every slot. Each request gives exactly one result beat on
// the m_ channel with the slot, the circular distance plus one, and a status.
// The ring size is written through the cfg channel, which is always ready;
// write it only while no request is in flight. Values above 1024 act as 1024.
// The search examines one 64-slot occupancy word per cycle. An allocate
// visits one ring word per search step up to the wrap and one more step to
// revisit the wanted slot's word; the ring's word count sets the bound.
// Clear and out-of-range requests end the search at once. After the edge that
// accepts a request the block searches, then loads the result into the output
// register in its done state and returns to idle to take the next request.
// One request is handled at a time; a new one is taken while an earlier
// result still waits in the output register.
// If the receiver stalls, the result holds in the output register and the
// block stops at the end of the following request until the result is taken.
// Reset frees all slots, sets the ring size to 1024 and empties the output.
module circular_first_free_slot_allocator
    import cffsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // wanted_slot[9:0], zero fill
    input  logic                s_tuser,   // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // assigned_slot[9:0], distance[20:10]
    output logic [STATUS_W-1:0] m_tuser,   // status
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data   // seats_in_use
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    cffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cffsa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
